FILE: src/look_at_view_matrix_assert.svh
// Assertion macros for the look-at view matrix block.
`ifndef LOOK_AT_VIEW_MATRIX_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_ASSERT_SVH

// Plain property, checked outside reset.
`define LAVM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication, checked outside reset.
`define LAVM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

FILE: src/lavm_pkg.sv
// Shared types and constants for the look-at view matrix block.
package lavm_pkg;

  localparam int FracBitsDef = 16;
  localparam int MinLenW     = 17;
  localparam logic [MinLenW-1:0] MinLenRst = 17'd1;
  localparam int SqrtSteps   = 32;

  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [31:0] target_x;
    logic signed [31:0] target_y;
    logic signed [31:0] target_z;
    logic signed [31:0] world_up_x;
    logic signed [31:0] world_up_y;
    logic signed [31:0] world_up_z;
  } lavm_in_t;

  typedef struct packed {
    logic signed [31:0] side_x;
    logic signed [31:0] side_y;
    logic signed [31:0] side_z;
    logic signed [31:0] cam_up_x;
    logic signed [31:0] cam_up_y;
    logic signed [31:0] cam_up_z;
    logic signed [31:0] back_x;
    logic signed [31:0] back_y;
    logic signed [31:0] back_z;
    logic signed [31:0] shift_x;
    logic signed [31:0] shift_y;
    logic signed [31:0] shift_z;
  } lavm_out_t;

  // normalize unit latency: scale, square, sum, sqrt steps, limit check,
  // one divide step per quotient bit, sign
  function automatic int lavm_norm_lat(int frac);
    return 3 + SqrtSteps + 1 + (frac + 1) + 1;
  endfunction

endpackage

FILE: src/look_at_view_matrix.sv
// Top level of the look-at view matrix block.
// Takes eye, target and world-up in signed fixed point and returns the
// twelve varying view matrix entries per transaction. The pipeline accepts
// one transaction per clock unless stalled; the path runs through two
// normalize units (each a 32-step integer square root and a one bit per
// stage divider). A stall while out_valid_o is high freezes the whole
// pipeline. The user must write min_length only while no transaction is in
// flight; the block itself does not enforce this.
`include "look_at_view_matrix_assert.svh"

module look_at_view_matrix import lavm_pkg::*; #(
  parameter int FRAC_BITS = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MinLenW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  lavm_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output lavm_out_t          out_data_o
);

  localparam int F    = FRAC_BITS;
  localparam int UW   = F + 2;
  localparam int NL   = lavm_norm_lat(F);
  localparam int VW1  = 33;
  localparam int PW1  = UW + 32;
  localparam int VW2  = PW1 + 1;
  localparam int CPW  = 2 * UW;
  localparam int UPW  = F + 3;
  localparam int DPW  = UPW + 32;
  localparam int SSW  = DPW + 3;
  localparam int Last = 2 * NL + 5;

  localparam logic signed [CPW:0]   HalfU = (CPW + 1)'(64'd1 << (F - 1));
  localparam logic signed [SSW-1:0] HalfD = SSW'(64'd1 << (F - 1));
  localparam logic signed [SSW-1:0] SatHi = SSW'(64'sh7fffffff);
  localparam logic signed [SSW-1:0] SatLo = -SatHi - SSW'(1);
  localparam logic signed [31:0]    UnitMax = 32'(64'd1 << F);

  logic en;
  logic [MinLenW-1:0] min_len_q;
  logic vld_q [Last+1];
  logic out_vld_q;

  assign en         = !(out_vld_q && out_stall_i);
  assign in_stall_o = !en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_len_q <= MinLenRst;
      out_vld_q <= 1'b0;
      for (int t = 0; t <= Last; t++) vld_q[t] <= 1'b0;
    end else begin
      if (cfg_we_i) min_len_q <= cfg_wdata_i;
      if (en) begin
        vld_q[0] <= in_valid_i;
        for (int t = 0; t < Last; t++) vld_q[t+1] <= vld_q[t];
        out_vld_q <= vld_q[Last];
      end
    end
  end

  // entry stage
  logic [2:0][VW1-1:0] dir_q;
  logic [2:0][31:0]    eye_dl [2*NL+5];
  logic [2:0][31:0]    wup_dl [NL+1];

  // normalize front
  logic [2:0][UW-1:0]  front;
  logic [2:0][UW-1:0]  front_dl [NL+5];

  lavm_norm #(.VW(VW1), .FRAC(F), .EXTRA(0)) u_norm_front (
    .clk_i     (clk_i),
    .en_i      (en),
    .min_len_i (min_len_q),
    .vec_i     (dir_q),
    .unit_o    (front)
  );

  // right = normalize(front x up)
  logic signed [PW1-1:0] c1_q [6];
  logic [2:0][VW2-1:0]   rraw_q;
  logic [2:0][UW-1:0]    right;
  logic [2:0][UW-1:0]    right_dl [3];
  logic signed [UW-1:0]  fa [3];
  logic signed [31:0]    wa [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      fa[i] = $signed(front[i]);
      wa[i] = $signed(wup_dl[NL][i]);
    end
  end

  lavm_norm #(.VW(VW2), .FRAC(F), .EXTRA(F)) u_norm_right (
    .clk_i     (clk_i),
    .en_i      (en),
    .min_len_i (min_len_q),
    .vec_i     (rraw_q),
    .unit_o    (right)
  );

  // cam_up = round(right x front)
  logic signed [UW-1:0]  ra [3];
  logic signed [UW-1:0]  fb [3];
  logic signed [CPW-1:0] u1_q [6];
  logic signed [CPW:0]   udiff [3];
  logic [2:0][UPW-1:0]   up_q, up_d1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ra[i] = $signed(right[i]);
      fb[i] = $signed(front_dl[NL+1][i]);
    end
    udiff[0] = (CPW + 1)'(u1_q[0]) - (CPW + 1)'(u1_q[1]);
    udiff[1] = (CPW + 1)'(u1_q[2]) - (CPW + 1)'(u1_q[3]);
    udiff[2] = (CPW + 1)'(u1_q[4]) - (CPW + 1)'(u1_q[5]);
  end

  // translation dot products
  logic signed [DPW-1:0] pr_q [3], pu_q [3], pf_q [3];
  logic signed [SSW-1:0] dr, du, df;

  always_comb begin
    dr = SSW'(pr_q[0]) + SSW'(pr_q[1]) + SSW'(pr_q[2]);
    du = SSW'(pu_q[0]) + SSW'(pu_q[1]) + SSW'(pu_q[2]);
    df = SSW'(pf_q[0]) + SSW'(pf_q[1]) + SSW'(pf_q[2]);
  end

  function automatic logic [31:0] rnd_sat(logic signed [SSW-1:0] x);
    logic signed [SSW-1:0] t;
    t = (x + HalfD) >>> F;
    if (t > SatHi) return 32'h7fffffff;
    if (t < SatLo) return 32'h80000000;
    return t[31:0];
  endfunction

  lavm_out_t out_q;
  logic signed [31:0] bx, by, bz;

  always_comb begin
    bx = 32'($signed(front_dl[NL+4][0]));
    by = 32'($signed(front_dl[NL+4][1]));
    bz = 32'($signed(front_dl[NL+4][2]));
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dir_q[0] <= $signed({in_data_i.target_x[31], in_data_i.target_x})
                - $signed({in_data_i.eye_x[31], in_data_i.eye_x});
      dir_q[1] <= $signed({in_data_i.target_y[31], in_data_i.target_y})
                - $signed({in_data_i.eye_y[31], in_data_i.eye_y});
      dir_q[2] <= $signed({in_data_i.target_z[31], in_data_i.target_z})
                - $signed({in_data_i.eye_z[31], in_data_i.eye_z});
      eye_dl[0] <= {in_data_i.eye_z, in_data_i.eye_y, in_data_i.eye_x};
      wup_dl[0] <= {in_data_i.world_up_z, in_data_i.world_up_y, in_data_i.world_up_x};
      for (int t = 0; t < 2 * NL + 4; t++) eye_dl[t+1] <= eye_dl[t];
      for (int t = 0; t < NL; t++) wup_dl[t+1] <= wup_dl[t];

      front_dl[0] <= front;
      for (int t = 0; t < NL + 4; t++) front_dl[t+1] <= front_dl[t];

      c1_q[0] <= fa[1] * wa[2];
      c1_q[1] <= fa[2] * wa[1];
      c1_q[2] <= fa[2] * wa[0];
      c1_q[3] <= fa[0] * wa[2];
      c1_q[4] <= fa[0] * wa[1];
      c1_q[5] <= fa[1] * wa[0];
      rraw_q[0] <= VW2'(c1_q[0]) - VW2'(c1_q[1]);
      rraw_q[1] <= VW2'(c1_q[2]) - VW2'(c1_q[3]);
      rraw_q[2] <= VW2'(c1_q[4]) - VW2'(c1_q[5]);

      right_dl[0] <= right;
      right_dl[1] <= right_dl[0];
      right_dl[2] <= right_dl[1];

      u1_q[0] <= ra[1] * fb[2];
      u1_q[1] <= ra[2] * fb[1];
      u1_q[2] <= ra[2] * fb[0];
      u1_q[3] <= ra[0] * fb[2];
      u1_q[4] <= ra[0] * fb[1];
      u1_q[5] <= ra[1] * fb[0];
      for (int i = 0; i < 3; i++) begin
        up_q[i] <= UPW'((udiff[i] + HalfU) >>> F);
      end
      up_d1_q <= up_q;

      for (int i = 0; i < 3; i++) begin
        pr_q[i] <= $signed(right_dl[1][i]) * $signed(eye_dl[2*NL+4][i]);
        pu_q[i] <= $signed(up_q[i]) * $signed(eye_dl[2*NL+4][i]);
        pf_q[i] <= $signed(front_dl[NL+3][i]) * $signed(eye_dl[2*NL+4][i]);
      end

      out_q.side_x   <= 32'($signed(right_dl[2][0]));
      out_q.side_y   <= 32'($signed(right_dl[2][1]));
      out_q.side_z   <= 32'($signed(right_dl[2][2]));
      out_q.cam_up_x <= 32'($signed(up_d1_q[0]));
      out_q.cam_up_y <= 32'($signed(up_d1_q[1]));
      out_q.cam_up_z <= 32'($signed(up_d1_q[2]));
      out_q.back_x   <= -bx;
      out_q.back_y   <= -by;
      out_q.back_z   <= -bz;
      out_q.shift_x  <= rnd_sat(-dr);
      out_q.shift_y  <= rnd_sat(-du);
      out_q.shift_z  <= rnd_sat(df);
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  `LAVM_ASSERT_IMP(a_side_range, out_vld_q,
    (out_q.side_x <= UnitMax) && (out_q.side_x >= -UnitMax) &&
    (out_q.side_y <= UnitMax) && (out_q.side_y >= -UnitMax) &&
    (out_q.side_z <= UnitMax) && (out_q.side_z >= -UnitMax),
    "side vector outside unit range")
  `LAVM_ASSERT_IMP(a_no_front_no_side,
    out_vld_q && out_q.back_x == 0 && out_q.back_y == 0 && out_q.back_z == 0,
    out_q.side_x == 0 && out_q.side_y == 0 && out_q.side_z == 0,
    "side nonzero with zero front")
  `LAVM_ASSERT_IMP(a_no_side_no_up,
    out_vld_q && out_q.side_x == 0 && out_q.side_y == 0 && out_q.side_z == 0,
    out_q.cam_up_x == 0 && out_q.cam_up_y == 0 && out_q.cam_up_z == 0,
    "camera up nonzero with zero side")
  `LAVM_ASSERT_IMP(a_out_source, out_vld_q && !$past(out_vld_q),
    $past(vld_q[Last]) && $past(en),
    "output valid without a transaction in the last stage")

endmodule

FILE: src/lavm_norm.sv
// Pipelined vector normalize: scale, integer sqrt, length limit, divide.
module lavm_norm import lavm_pkg::*; #(
  parameter int VW    = 33,
  parameter int FRAC  = FracBitsDef,
  parameter int EXTRA = 0
) (
  input  logic                        clk_i,
  input  logic                        en_i,
  input  logic [MinLenW-1:0]          min_len_i,
  input  logic [2:0][VW-1:0]          vec_i,
  output logic [2:0][FRAC+1:0]        unit_o
);

  localparam int Q  = FRAC + 1;
  localparam int NW = 32 + FRAC;
  localparam int PW = $clog2(VW);
  localparam int SW = SqrtSteps;

  // stage 1: magnitude, leading one, scale into [2^30, 2^31)
  logic [2:0][VW-1:0] mag;
  logic [2:0]         neg_d;
  logic [VW-1:0]      mmax;
  logic [PW-1:0]      msb;
  logic [VW+30:0]     wide [3];
  logic [2:0][30:0]   magn;
  logic signed [7:0]  k_d;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg_d[i] = vec_i[i][VW-1];
      mag[i]   = neg_d[i] ? (~vec_i[i] + 1'b1) : vec_i[i];
    end
    mmax = mag[0];
    if (mag[1] > mmax) mmax = mag[1];
    if (mag[2] > mmax) mmax = mag[2];
    msb = '0;
    for (int b = 0; b < VW; b++) begin
      if (mmax[b]) msb = PW'(b);
    end
    k_d = 8'(30 - int'(msb));
    for (int i = 0; i < 3; i++) begin
      wide[i] = {31'b0, mag[i]};
      if (msb > PW'(30)) wide[i] = wide[i] >> (msb - PW'(30));
      else wide[i] = wide[i] << (PW'(30) - msb);
      magn[i] = wide[i][30:0];
    end
  end

  logic [2:0][30:0]  mag1_q, mag2_q;
  logic [2:0]        neg1_q, neg2_q;
  logic              zero1_q, zero2_q;
  logic signed [7:0] k1_q, k2_q;
  logic [2:0][61:0]  sq2_q;

  // sqrt pipeline, index 0 holds the sum of squares
  logic [63:0]       sq_s_q [SW+1];
  logic [63:0]       sq_r_q [SW+1];
  logic [2:0][30:0]  sd_mag_q [SW+1];
  logic [2:0]        sd_neg_q [SW+1];
  logic              sd_zero_q [SW+1];
  logic signed [7:0] sd_k_q [SW+1];
  logic [64:0]       trial [SW];
  logic              take [SW];

  always_comb begin
    for (int j = 0; j < SW; j++) begin
      trial[j] = {1'b0, sq_r_q[j]} + {1'b0, (64'd1 << (62 - 2 * j))};
      take[j]  = {1'b0, sq_s_q[j]} >= trial[j];
    end
  end

  // limit check and divide setup
  logic [31:0]        len;
  logic signed [7:0]  kk;
  logic [55:0]        minsh;
  logic               below;
  logic [NW-1:0]      num [3];

  always_comb begin
    len   = sq_r_q[SW][31:0];
    kk    = sd_k_q[SW] + 8'(EXTRA);
    minsh = {39'b0, min_len_i} << kk[5:0];
    if (kk < 8'sd0) below = 1'b0;
    else if (kk >= 8'sd40) below = min_len_i != '0;
    else below = {24'b0, len} < minsh;
    for (int i = 0; i < 3; i++) begin
      num[i] = {1'b0, sd_mag_q[SW][i], {FRAC{1'b0}}} + NW'(len >> 1);
    end
  end

  // restoring divide, index 0 holds the setup
  logic [2:0][31:0]   dv_rem_q [Q+1];
  logic [2:0][Q-1:0]  dv_n_q [Q+1];
  logic [2:0][Q-1:0]  dv_quo_q [Q+1];
  logic [31:0]        dv_len_q [Q+1];
  logic               dv_kill_q [Q+1];
  logic [2:0]         dv_neg_q [Q+1];
  logic [32:0]        dtry [Q][3];
  logic               dge [Q][3];

  always_comb begin
    for (int j = 0; j < Q; j++) begin
      for (int i = 0; i < 3; i++) begin
        dtry[j][i] = {dv_rem_q[j][i], dv_n_q[j][i][Q-1-j]};
        dge[j][i]  = dtry[j][i] >= {1'b0, dv_len_q[j]};
      end
    end
  end

  logic [2:0][FRAC+1:0] unit_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag1_q  <= magn;
      neg1_q  <= neg_d;
      zero1_q <= mmax == '0;
      k1_q    <= k_d;

      for (int i = 0; i < 3; i++) begin
        sq2_q[i] <= 62'(mag1_q[i]) * 62'(mag1_q[i]);
      end
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      zero2_q <= zero1_q;
      k2_q    <= k1_q;

      sq_s_q[0]    <= 64'(sq2_q[0]) + 64'(sq2_q[1]) + 64'(sq2_q[2]);
      sq_r_q[0]    <= '0;
      sd_mag_q[0]  <= mag2_q;
      sd_neg_q[0]  <= neg2_q;
      sd_zero_q[0] <= zero2_q;
      sd_k_q[0]    <= k2_q;

      for (int j = 0; j < SW; j++) begin
        if (take[j]) begin
          sq_s_q[j+1] <= sq_s_q[j] - trial[j][63:0];
          sq_r_q[j+1] <= (sq_r_q[j] >> 1) + (64'd1 << (62 - 2 * j));
        end else begin
          sq_s_q[j+1] <= sq_s_q[j];
          sq_r_q[j+1] <= sq_r_q[j] >> 1;
        end
        sd_mag_q[j+1]  <= sd_mag_q[j];
        sd_neg_q[j+1]  <= sd_neg_q[j];
        sd_zero_q[j+1] <= sd_zero_q[j];
        sd_k_q[j+1]    <= sd_k_q[j];
      end

      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= 32'(num[i][NW-1:Q]);
        dv_n_q[0][i]   <= num[i][Q-1:0];
        dv_quo_q[0][i] <= '0;
      end
      dv_len_q[0]  <= len;
      dv_kill_q[0] <= sd_zero_q[SW] || below;
      dv_neg_q[0]  <= sd_neg_q[SW];

      for (int j = 0; j < Q; j++) begin
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= dge[j][i] ? 32'(dtry[j][i] - {1'b0, dv_len_q[j]})
                                        : dtry[j][i][31:0];
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][Q-2:0], dge[j][i]};
        end
        dv_n_q[j+1]    <= dv_n_q[j];
        dv_len_q[j+1]  <= dv_len_q[j];
        dv_kill_q[j+1] <= dv_kill_q[j];
        dv_neg_q[j+1]  <= dv_neg_q[j];
      end

      for (int i = 0; i < 3; i++) begin
        if (dv_kill_q[Q]) unit_q[i] <= '0;
        else if (dv_neg_q[Q][i]) unit_q[i] <= -{1'b0, dv_quo_q[Q][i]};
        else unit_q[i] <= {1'b0, dv_quo_q[Q][i]};
      end
    end
  end

  assign unit_o = unit_q;

endmodule

FILE: bench/lavm_checker.sv
// Checker for the look-at view matrix block: predicts each result and compares it.
module lavm_checker import lavm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [MinLenW-1:0] cfg_wdata_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  lavm_in_t           in_data_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  lavm_out_t          out_data_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 checked_o
);

  typedef longint vec3_t [3];

  localparam int Frac = FracBitsDef;

  logic [MinLenW-1:0] min_len;
  lavm_out_t          expected_views[$];
  string              field_name [12] = '{"side_x", "side_y", "side_z", "cam_up_x",
    "cam_up_y", "cam_up_z", "back_x", "back_y", "back_z", "shift_x", "shift_y", "shift_z"};

  function automatic longint unsigned sqrt_floor(longint unsigned s);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > s) b = b >> 2;
    while (b != 0) begin
      if (s >= r + b) begin
        s = s - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint round_frac(longint x);
    return (x + (64'sd1 <<< (Frac - 1))) >>> Frac;
  endfunction

  function automatic logic [31:0] clamp32(longint x);
    if (x > 64'sd2147483647) return 32'h7fff_ffff;
    if (x < -64'sd2147483648) return 32'h8000_0000;
    return x[31:0];
  endfunction

  function automatic void unit_vec(input vec3_t v, input int extra, output vec3_t u);
    longint unsigned mag [3];
    longint unsigned m, sum, len, q;
    bit              neg [3];
    bit              below;
    int              k;
    m = 0;
    sum = 0;
    k = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : longint'(v[i]);
      if (mag[i] > m) m = mag[i];
      u[i] = 0;
    end
    if (m == 0) return;
    while (m >= 64'h8000_0000) begin
      m = m >> 1;
      k--;
    end
    while (m < 64'h4000_0000) begin
      m = m << 1;
      k++;
    end
    for (int i = 0; i < 3; i++) begin
      if (k < 0) mag[i] = mag[i] >> (-k);
      else mag[i] = mag[i] << k;
      sum = sum + mag[i] * mag[i];
    end
    len = sqrt_floor(sum);
    k = k + extra;
    if (k < 0) below = 1'b0;
    else if (k >= 40) below = min_len != 0;
    else below = len < ({47'd0, min_len} << k);
    if (below) return;
    for (int i = 0; i < 3; i++) begin
      q = ((mag[i] << Frac) + (len >> 1)) / len;
      u[i] = neg[i] ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic void cross3(input vec3_t a, input vec3_t b, output vec3_t r);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic lavm_out_t view_matrix(lavm_in_t d);
    vec3_t     eye, wup, dir, front, rraw, right, uraw, up;
    longint    dr, du, df;
    lavm_out_t o;
    eye = '{longint'(d.eye_x), longint'(d.eye_y), longint'(d.eye_z)};
    wup = '{longint'(d.world_up_x), longint'(d.world_up_y), longint'(d.world_up_z)};
    dir[0] = longint'(d.target_x) - eye[0];
    dir[1] = longint'(d.target_y) - eye[1];
    dir[2] = longint'(d.target_z) - eye[2];
    unit_vec(dir, 0, front);
    cross3(front, wup, rraw);
    unit_vec(rraw, Frac, right);
    cross3(right, front, uraw);
    dr = 0;
    du = 0;
    df = 0;
    for (int i = 0; i < 3; i++) begin
      up[i] = round_frac(uraw[i]);
      dr = dr + right[i] * eye[i];
      du = du + up[i] * eye[i];
      df = df + front[i] * eye[i];
    end
    o.side_x = right[0][31:0];
    o.side_y = right[1][31:0];
    o.side_z = right[2][31:0];
    o.cam_up_x = up[0][31:0];
    o.cam_up_y = up[1][31:0];
    o.cam_up_z = up[2][31:0];
    o.back_x = 32'(-front[0]);
    o.back_y = 32'(-front[1]);
    o.back_z = 32'(-front[2]);
    o.shift_x = clamp32(round_frac(-dr));
    o.shift_y = clamp32(round_frac(-du));
    o.shift_z = clamp32(round_frac(df));
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    lavm_out_t        exp_v;
    logic [383:0]     ev, av;
    bit               bad;
    if (!rst_ni) begin
      min_len = MinLenRst;
      errors_o = 0;
      checked_o = 0;
      expected_views.delete();
    end else begin
      if (cfg_we_i) min_len = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) expected_views.push_back(view_matrix(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        if (expected_views.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result transaction: %h", out_data_i);
        end else begin
          exp_v = expected_views.pop_front();
          ev = exp_v;
          av = out_data_i;
          bad = 1'b0;
          for (int i = 0; i < 12; i++) begin
            if (ev[(11 - i) * 32 +: 32] !== av[(11 - i) * 32 +: 32]) begin
              if (!bad) errors_o++;
              if (errors_o <= 10)
                $display("result %0d field %s: expected %h, got %h", checked_o,
                         field_name[i], ev[(11 - i) * 32 +: 32], av[(11 - i) * 32 +: 32]);
              bad = 1'b1;
            end
          end
        end
        checked_o++;
      end
    end
    pending_o = expected_views.size();
  end

endmodule

FILE: bench/look_at_view_matrix_test.sv
// Testbench top for the look-at view matrix block: stimulus, flow control and verdict.
module look_at_view_matrix_test;
  import lavm_pkg::*;

  localparam int IdleLimit = 5000;
  localparam int Drain     = 130;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [MinLenW-1:0] cfg_wdata;
  logic               in_valid;
  logic               in_stall;
  lavm_in_t           in_data;
  logic               out_valid;
  logic               out_stall;
  lavm_out_t          out_data;
  int                 errors, pending, checked;
  int                 sent;
  int                 send_idle_pct, recv_idle_pct;
  int                 idle_cycles;
  bit                 hold_req;

  look_at_view_matrix dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  lavm_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_i (in_stall),
    .in_data_i  (in_data),
    .out_valid_i(out_valid),
    .out_stall_i(out_stall),
    .out_data_i (out_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // receiver side, with a long hold-off when hold_req is set
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
        hold_req = 1'b0;
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog: no transaction for %0d cycles", IdleLimit);
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic logic [31:0] coord(int bits);
    return int'($urandom) >>> (32 - bits);
  endfunction

  function automatic lavm_in_t rand_view();
    lavm_in_t d;
    int       b;
    b = $urandom_range(4, 24);
    d = {coord(b), coord(b), coord(b), coord(b), coord(b), coord(b),
         coord(b), coord(b), coord(b)};
    case ($urandom_range(9))
      0: d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom};
      1: begin
        d.target_x = d.eye_x;
        d.target_y = d.eye_y;
        d.target_z = d.eye_z;
      end
      2: begin
        d.world_up_x = d.target_x - d.eye_x;
        d.world_up_y = d.target_y - d.eye_y;
        d.world_up_z = d.target_z - d.eye_z;
      end
      3: begin
        d.target_x = d.eye_x + coord(3);
        d.target_y = d.eye_y + coord(3);
        d.target_z = d.eye_z + coord(3);
      end
      4: begin
        d.eye_x = $urandom;
        d.eye_y = $urandom;
        d.eye_z = $urandom;
      end
      default: ;
    endcase
    return d;
  endfunction

  task automatic send(lavm_in_t d);
    logic s;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= d;
    sent++;
    do begin
      @(negedge clk_i);
      s = in_stall;
      @(posedge clk_i);
    end while (s);
  endtask

  task automatic settle_and_write(logic [MinLenW-1:0] v);
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (Drain) @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(int n, int sp, int rp);
    send_idle_pct = sp;
    recv_idle_pct = rp;
    repeat (n) send(rand_view());
  endtask

  localparam logic [31:0] Pmax = 32'h7fff_ffff;
  localparam logic [31:0] Nmax = 32'h8000_0000;
  localparam logic [31:0] One  = 32'h0001_0000;

  initial begin
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_data = '0;
    hold_req = 1'b0;
    idle_cycles = 0;
    sent = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: degenerate vectors, extremes, saturation
    send('0);
    send({Nmax, Nmax, Nmax, Pmax, Pmax, Pmax, Pmax, Nmax, Pmax});
    send({Pmax, Pmax, Pmax, Nmax, Nmax, Nmax, Nmax, Pmax, Nmax});
    send({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, Nmax, 32'd0, One, 32'd0});
    send({32'd0, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, One, 32'd0});
    send({32'd0, 32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, Nmax, 32'd0});
    send({One, One, One, One, One, One, 32'd0, One, 32'd0});
    send({32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0, One, 32'd0});
    send({32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0});
    send({Pmax, Pmax, Pmax, 32'd0, 32'd0, 32'd0, 32'd0, One, 32'd0});
    send({Nmax, Nmax, Nmax, Pmax, 32'd0, 32'd0, 32'd0, 32'd0, One});
    send({Nmax, Pmax, Nmax, 32'd0, 32'd0, 32'd0, 32'd1, 32'd1, 32'd1});
    send({32'd5, 32'd7, 32'd9, 32'd5, 32'd7, 32'd9, One, One, One});
    send({32'hffff_ffff, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, Pmax, Pmax, Pmax});
    send({32'h0003_0000, 32'h0002_0000, 32'h0001_0000, 32'd0, 32'd0, 32'd0,
          32'hffff_0000, 32'h0001_0000, 32'd0});

    settle_and_write(17'd0);
    send('0);
    send({32'd0, 32'd0, 32'd0, 32'd1, 32'd0, 32'd0, 32'd0, 32'd1, 32'd0});
    // long hold-off on the output while items keep coming
    hold_req = 1'b1;
    run_phase(250, 0, 0);
    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    run_phase(300, 12, 87);

    settle_and_write(17'd65536);
    send({32'd0, 32'd0, 32'd0, 32'hffff, 32'd0, 32'd0, 32'd0, One, 32'd0});
    send({32'd0, 32'd0, 32'd0, One, 32'd0, 32'd0, 32'd0, 32'd0, One});
    run_phase(550, 87, 12);

    settle_and_write(17'($urandom_range(2, 65535)));
    run_phase(550, 0, 0);

    in_valid <= 1'b0;
    @(posedge clk_i);
    wait (pending == 0);
    repeat (Drain) @(posedge clk_i);
    $display("%0d view setups sent, %0d results checked", sent, checked);
    $display("min_length swept over 1, 0, 65536 and a random value, incl. output hold-off");
    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
